@@ src/crtn_pkg.sv @@
// Shared types, constants and the seed table for the cube root block.
// No dependencies.
package crtn_pkg;

  localparam int ValW     = 64;  // operand width
  localparam int RootW    = 22;  // result width
  localparam int EstW     = 23;  // seed estimate width
  localparam int DivW     = 48;  // divisor / remainder width
  localparam int QuotW    = 32;  // kept quotient bits
  localparam int SmallW   = 3;   // root width on the table-only path
  localparam int PosW     = 7;
  localparam int KW       = 5;

  // item handed from the front to the back
  typedef struct packed {
    logic              tbl_path;
    logic [SmallW-1:0] small_root;
    logic [EstW-1:0]   est;
    logic [ValW-1:0]   value;
  } work_t;

  function automatic logic [7:0] seed_tbl(input logic [5:0] i);
    logic [7:0] r;
    case (i)
      6'd0:  r = 8'd0;   6'd1:  r = 8'd54;  6'd2:  r = 8'd54;  6'd3:  r = 8'd54;
      6'd4:  r = 8'd118; 6'd5:  r = 8'd118; 6'd6:  r = 8'd118; 6'd7:  r = 8'd118;
      6'd8:  r = 8'd123; 6'd9:  r = 8'd129; 6'd10: r = 8'd134; 6'd11: r = 8'd138;
      6'd12: r = 8'd143; 6'd13: r = 8'd147; 6'd14: r = 8'd151; 6'd15: r = 8'd156;
      6'd16: r = 8'd157; 6'd17: r = 8'd161; 6'd18: r = 8'd164; 6'd19: r = 8'd168;
      6'd20: r = 8'd170; 6'd21: r = 8'd173; 6'd22: r = 8'd176; 6'd23: r = 8'd179;
      6'd24: r = 8'd181; 6'd25: r = 8'd185; 6'd26: r = 8'd187; 6'd27: r = 8'd190;
      6'd28: r = 8'd192; 6'd29: r = 8'd194; 6'd30: r = 8'd197; 6'd31: r = 8'd199;
      6'd32: r = 8'd200; 6'd33: r = 8'd202; 6'd34: r = 8'd204; 6'd35: r = 8'd206;
      6'd36: r = 8'd209; 6'd37: r = 8'd211; 6'd38: r = 8'd213; 6'd39: r = 8'd215;
      6'd40: r = 8'd217; 6'd41: r = 8'd219; 6'd42: r = 8'd221; 6'd43: r = 8'd222;
      6'd44: r = 8'd224; 6'd45: r = 8'd225; 6'd46: r = 8'd227; 6'd47: r = 8'd229;
      6'd48: r = 8'd231; 6'd49: r = 8'd232; 6'd50: r = 8'd234; 6'd51: r = 8'd236;
      6'd52: r = 8'd237; 6'd53: r = 8'd239; 6'd54: r = 8'd240; 6'd55: r = 8'd242;
      6'd56: r = 8'd244; 6'd57: r = 8'd245; 6'd58: r = 8'd246; 6'd59: r = 8'd248;
      6'd60: r = 8'd250; 6'd61: r = 8'd251; 6'd62: r = 8'd252; 6'd63: r = 8'd254;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/crtn_front.sv @@
// Front end: accepts operands, finds the leading bit, reads the seed table.
// Depends on crtn_pkg.
module crtn_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [crtn_pkg::ValW-1:0] in_value,
  output logic                  wr_valid,
  input  logic                  wr_ready,
  output crtn_pkg::work_t       wr_item
);

  logic                          va_r, vb_r;
  logic [crtn_pkg::ValW-1:0]     val_a_r;
  logic [crtn_pkg::KW-1:0]       k_a_r;
  logic                          small_a_r;
  crtn_pkg::work_t               item_b_r;
  logic                          rdy_b;

  logic [crtn_pkg::PosW-1:0]     pos;
  logic [12:0]                   pos84;
  logic [crtn_pkg::KW-1:0]       k_nxt;
  logic [6:0]                    sh3;
  logic [crtn_pkg::ValW-1:0]     shifted;
  logic [8:0]                    seed9;
  logic [31:0]                   seed_sh;
  logic [8:0]                    small_sum;

  always_comb begin
    pos = '0;
    for (int i = 0; i < crtn_pkg::ValW; i++) begin
      if (in_value[i]) pos = crtn_pkg::PosW'(i + 1);
    end
    pos84 = 13'(pos) * 13'd84;
    k_nxt = pos84[12:8] - crtn_pkg::KW'(1);
  end

  always_comb begin
    sh3       = 7'(k_a_r) * 7'd3;
    shifted   = val_a_r >> sh3;
    seed9     = 9'(crtn_pkg::seed_tbl(shifted[5:0])) + 9'd10;
    seed_sh   = 32'(seed9) << k_a_r;
    small_sum = 9'(crtn_pkg::seed_tbl(val_a_r[5:0])) + 9'd35;
  end

  assign rdy_b    = !vb_r || wr_ready;
  assign in_ready = !va_r || rdy_b;
  assign wr_valid = vb_r;
  assign wr_item  = item_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (in_ready) va_r <= in_valid;
      if (rdy_b)    vb_r <= va_r;
    end
    if (in_ready) begin
      val_a_r   <= in_value;
      k_a_r     <= k_nxt;
      small_a_r <= (pos < crtn_pkg::PosW'(7));
    end
    if (rdy_b) begin
      item_b_r.value      <= val_a_r;
      item_b_r.tbl_path   <= small_a_r;
      item_b_r.small_root <= small_sum[8:6];
      item_b_r.est        <= seed_sh[28:6];
    end
  end

endmodule

@@ src/crtn_queue.sv @@
// Two-entry queue between the front and the back.
// Depends on crtn_pkg.
module crtn_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  crtn_pkg::work_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output crtn_pkg::work_t rd_item
);

  crtn_pkg::work_t mem [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= !wp_r;
      if (do_rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
    if (do_wr) mem[wp_r] <= wr_item;
  end

endmodule

@@ src/crtn_back.sv @@
// Back end: divisor product, bit-per-stage restoring divider, Newton update.
// Depends on crtn_pkg.
module crtn_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_valid,
  output logic                       rd_ready,
  input  crtn_pkg::work_t            rd_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [crtn_pkg::RootW-1:0] out_root
);

  localparam int N = crtn_pkg::ValW;

  logic                          en;
  logic [N+2:0]                  vld_r;
  logic                          sm_r    [N+1];
  logic [crtn_pkg::SmallW-1:0]   sroot_r [N+1];
  logic [crtn_pkg::EstW-1:0]     est_r   [N+1];
  logic [crtn_pkg::ValW-1:0]     val_r   [N+1];
  logic [crtn_pkg::DivW-1:0]     div_r   [N+1];
  logic [crtn_pkg::DivW-1:0]     rem_r   [N+1];
  logic [crtn_pkg::QuotW-1:0]    quo_r   [N+1];
  logic                          sm_s_r;
  logic [crtn_pkg::SmallW-1:0]   sroot_s_r;
  logic [31:0]                   sum_r;
  logic [31:0]                   prod;
  logic [crtn_pkg::RootW-1:0]    root_r;
  logic [45:0]                   mul;

  assign en        = !vld_r[N+2] || out_ready;
  assign rd_ready  = en;
  assign out_valid = vld_r[N+2];
  assign out_root  = root_r;
  assign mul       = 46'(rd_item.est) * 46'(rd_item.est - crtn_pkg::EstW'(1));
  assign prod      = sum_r * 32'd341;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N+1:0], rd_valid};
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (en) begin
      sm_r[0]    <= rd_item.tbl_path;
      sroot_r[0] <= rd_item.small_root;
      est_r[0]   <= rd_item.est;
      val_r[0]   <= rd_item.value;
      div_r[0]   <= crtn_pkg::DivW'(mul);
      rem_r[0]   <= '0;
      quo_r[0]   <= '0;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < N; j++) begin : g_div
    logic [crtn_pkg::DivW:0] t;
    logic                    ge;
    always_comb begin
      t  = {rem_r[j], val_r[j][N-1-j]};
      ge = (t >= {1'b0, div_r[j]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sm_r[j+1]    <= sm_r[j];
        sroot_r[j+1] <= sroot_r[j];
        est_r[j+1]   <= est_r[j];
        val_r[j+1]   <= val_r[j];
        div_r[j+1]   <= div_r[j];
        rem_r[j+1]   <= ge ? crtn_pkg::DivW'(t - {1'b0, div_r[j]})
                           : crtn_pkg::DivW'(t);
        quo_r[j+1]   <= {quo_r[j][crtn_pkg::QuotW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_s_r    <= sm_r[N];
      sroot_s_r <= sroot_r[N];
      sum_r     <= {8'd0, est_r[N], 1'b0} + quo_r[N];
      root_r    <= sm_s_r ? crtn_pkg::RootW'(sroot_s_r) : prod[31:10];
    end
  end

endmodule

@@ src/cube_root_table_newton.sv @@
// Approximate integer cube root of a 64-bit operand.
// Slave stream in_* carries operands, master stream out_* carries roots.
// An item moves when tvalid and tready are both high at a rising edge.
// Each accepted operand yields exactly one root, in order.
// From the input accept edge to out_tvalid an operand passes two front
// stages (leading-bit search, seed table), one queue slot, the divisor
// product, 64 divider stages (one quotient bit each), the Newton sum and
// the product by 341 in the output register; the first stage loads at
// the accept edge itself.
// Throughput is one item per cycle while out_tready stays high.
// The front and back are split by a two-entry queue; when out_tready is
// low the back pipeline holds, the queue fills, then in_tready drops.
// Reset (rst_n low, synchronous) empties every stage and the queue; no
// result is pending after reset.
// Depends on crtn_pkg, crtn_front, crtn_queue, crtn_back.
module cube_root_table_newton (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [21:0] root, [23:22] zero
);

  logic                       q_wr_valid, q_wr_ready;
  logic                       q_rd_valid, q_rd_ready;
  crtn_pkg::work_t            q_wr_item, q_rd_item;
  logic [crtn_pkg::RootW-1:0] root;

  crtn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_value (in_tdata),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_item  (q_wr_item)
  );

  crtn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_item  (q_wr_item),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_item  (q_rd_item)
  );

  crtn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (q_rd_valid),
    .rd_ready  (q_rd_ready),
    .rd_item   (q_rd_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_root  (root)
  );

  assign out_tdata = {2'b00, root};

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for cube_root_table_newton: random and corner operands,
// predicted roots compared in order. Depends on crtn_pkg and the block's RTL.
module tb_top;

  localparam int LATENCY   = 70;
  localparam int STALL_MAX = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // [63:0] value
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [21:0] root, [23:22] zero

  logic [crtn_pkg::RootW-1:0] roots_due[$];
  int  mismatches;
  int  roots_seen;
  int  idle_cycles;
  bit  in_gaps;
  bit  out_stalls;
  bit  timed_out;

  cube_root_table_newton uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // seed values, kept apart from the package function
  function automatic logic [7:0] seed_of(input logic [5:0] i);
    logic [7:0] t [64];
    t = '{8'd0, 8'd54, 8'd54, 8'd54, 8'd118, 8'd118, 8'd118, 8'd118,
          8'd123, 8'd129, 8'd134, 8'd138, 8'd143, 8'd147, 8'd151, 8'd156,
          8'd157, 8'd161, 8'd164, 8'd168, 8'd170, 8'd173, 8'd176, 8'd179,
          8'd181, 8'd185, 8'd187, 8'd190, 8'd192, 8'd194, 8'd197, 8'd199,
          8'd200, 8'd202, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd215,
          8'd217, 8'd219, 8'd221, 8'd222, 8'd224, 8'd225, 8'd227, 8'd229,
          8'd231, 8'd232, 8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242,
          8'd244, 8'd245, 8'd246, 8'd248, 8'd250, 8'd251, 8'd252, 8'd254};
    return t[i];
  endfunction

  function automatic logic [crtn_pkg::RootW-1:0] cube_root(input logic [63:0] v);
    int unsigned pos, k, est, quot;
    logic [5:0]  idx;
    logic [63:0] dvs;
    pos = 0;
    for (int b = 0; b < 64; b++) if (v[b]) pos = b + 1;
    if (pos < 7) return crtn_pkg::RootW'((32'(seed_of(v[5:0])) + 35) >> 6);
    k   = ((pos * 84) >> 8) - 1;
    idx = 6'(v >> (k * 3));
    est = ((32'(seed_of(idx)) + 10) << k) >> 6;
    dvs = 64'(est) * 64'(est - 1);
    quot = (dvs != 0) ? 32'(v / dvs) : 0;
    est = 2 * est + quot;
    est = (est * 341) >> 10;
    return crtn_pkg::RootW'(est);
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        roots_seen++;
        if (roots_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected root %h", out_tdata);
        end else begin
          logic [crtn_pkg::RootW-1:0] want;
          want = roots_due.pop_front();
          if (out_tdata !== {2'b00, want}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("root mismatch: expected %h, got %h", want, out_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_MAX && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog: no progress");
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver backpressure in bursts
  initial begin
    int n;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_stalls && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 18);
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_value(input logic [63:0] v);
    if (in_gaps && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    roots_due.push_back(cube_root(v));
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_corners();
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd63);
    send_value(64'd64);
    send_value(64'd65);
    send_value(64'd127);
    send_value(64'd128);
    send_value(64'd1000);
    send_value(64'd1_000_000_000);
    send_value(64'hFFFF_FFFF);
    send_value(64'h1_0000_0000);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'h5555_5555_5555_5555);
  endtask

  task automatic test_table_range();
    for (int i = 0; i < 64; i += 7) send_value(64'(i));
  endtask

  // exponents spread evenly so every seed shift is exercised
  task automatic test_random(input int count);
    logic [63:0] v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: v = rand64();
        1: v = 64'($urandom_range(0, 63));
        2: v = rand64() >> $urandom_range(0, 63);
        default: v = 64'($urandom_range(2, 5000)) ** 3 + 64'($urandom_range(0, 2)) - 1;
      endcase
      send_value(v);
    end
  endtask

  task automatic drain();
    while (roots_due.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mismatches = 0;
    roots_seen = 0;
    timed_out = 1'b0;
    in_gaps = 1'b1;
    out_stalls = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_corners();
    test_table_range();
    test_random(1500);
    in_gaps = 1'b0;
    out_stalls = 1'b0;
    test_random(300);
    in_tvalid <= 1'b0;
    drain();
    $display("run covered corner, table-range and random operands: %0d roots checked",
             roots_seen);
    if (mismatches == 0 && roots_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d roots missing", mismatches, roots_due.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
